FILE: hdl/dwe_pkg.sv
// dwe_pkg: shared constants and types for the dictionary word expander
// no dependencies
`timescale 1ns / 1ps
package dwe_pkg;
    localparam int DICT_WORDS   = 131072;
    localparam int DICT_BYTES   = 1048576;
    localparam int MAX_WORD_LEN = 62;
    localparam int WA_W = $clog2(DICT_BYTES);       // dictionary byte address
    localparam int WI_W = $clog2(DICT_WORDS + 1);   // word index / count
    localparam int LP_W = WA_W + 1;                 // load position
    localparam int LEN_W = 6;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0, MODE_STREAM = 2'd1, MODE_END = 2'd2, MODE_NONE = 2'd3
    } t_mode;
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0, KIND_OK = 2'd1, KIND_ERR = 2'd2, KIND_NONE = 2'd3
    } t_kind;
    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0, PH_ESCAPE = 2'd1, PH_INDEX = 2'd2, PH_WORDESC = 2'd3
    } t_phase;
    localparam logic [1:0] CASE_PLAIN = 2'd0;
    localparam logic [1:0] CASE_FIRST = 2'd1;
    localparam logic [1:0] CASE_ALL   = 2'd2;
    localparam logic [7:0] CH_NL = 8'h0a;

    function automatic logic is_upper(input logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5a;
    endfunction
    function automatic logic is_lower(input logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7a;
    endfunction
    function automatic logic is_send(input logic [7:0] c);
        return c == 8'h2e || c == 8'h3f || c == 8'h21;
    endfunction
endpackage

FILE: hdl/dwe_outq.sv
// dwe_outq: result output register with a one-entry skid stage
// depends on dwe_pkg
`timescale 1ns / 1ps
module dwe_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dwe_pkg::t_kind      i_kind,
    input  logic [7:0]          i_byte,
    input  logic [31:0]         i_count,
    input  logic                i_last,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output dwe_pkg::t_kind      o_kind,
    output logic [7:0]          o_byte,
    output logic [31:0]         o_count,
    output logic                o_last
);
    import dwe_pkg::*;
    logic        r_v0, r_v1;
    t_kind       r_k0, r_k1;
    logic [7:0]  r_b0, r_b1;
    logic [31:0] r_c0, r_c1;
    logic        r_l0, r_l1;
    logic        w_pop;

    assign w_pop   = r_v0 && i_ready;
    assign o_space = !r_v1;
    assign o_valid = r_v0;
    assign o_kind  = r_k0;
    assign o_byte  = r_b0;
    assign o_count = r_c0;
    assign o_last  = r_l0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (!r_v0 || w_pop) begin
                if (r_v1) begin
                    r_v0 <= 1'b1;
                    r_v1 <= i_valid;
                end else begin
                    r_v0 <= i_valid;
                end
            end else if (i_valid) begin
                r_v1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_v0 || w_pop) begin
            if (r_v1) begin
                r_k0 <= r_k1; r_b0 <= r_b1; r_c0 <= r_c1; r_l0 <= r_l1;
                r_k1 <= i_kind; r_b1 <= i_byte; r_c1 <= i_count; r_l1 <= i_last;
            end else begin
                r_k0 <= i_kind; r_b0 <= i_byte; r_c0 <= i_count; r_l0 <= i_last;
            end
        end else if (i_valid) begin
            r_k1 <= i_kind; r_b1 <= i_byte; r_c1 <= i_count; r_l1 <= i_last;
        end
    end
endmodule

FILE: hdl/dictionary_word_expander.sv
// dictionary_word_expander: loads a word dictionary, then expands coded streams
// depends on dwe_pkg and dwe_outq
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | i_mode, i_data_byte
//  out     | output    | o_valid / i_ready  | o_kind, o_out_byte, o_byte_count, o_last
//  cfg     | input     | psel/penable/pready| paddr, pwdata, prdata (out_limit at 0)
//
// a load byte or plain stream byte passes S_IDLE and S_DEC; a word passes S_ST0 and S_ST1,
// then S_RDCH and S_EMIT per letter with one dictionary read each; end of stream adds S_TAIL
// ws_mem and word_mem have one read and one write port each, no clearing pass
// reset is synchronous; stream state returns to reset at each end of stream
// output backpressure stalls the sequencer; bytes are dropped only beyond out_limit
`timescale 1ns / 1ps
module dictionary_word_expander (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic [31:0]         o_byte_count,
    output logic                o_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import dwe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_ST0   = 7'b0000100,
        S_ST1   = 7'b0001000,
        S_RDCH  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_TAIL  = 7'b1000000
    } t_state;

    logic [31:0]     r_limit;
    t_state          r_st;
    t_mode           r_mode;
    logic [7:0]      r_b;
    logic [7:0]      word_mem [DICT_BYTES];
    logic [LP_W-1:0] ws_mem [DICT_WORDS+1];
    logic [7:0]      r_ch;
    logic [LP_W-1:0] r_ws;
    logic [WI_W-1:0] r_words;
    logic [LP_W-1:0] r_lpos;
    logic [2:0]      r_hdr;
    logic [7:0]      r_code [4];
    logic            r_capn;
    t_phase          r_ph;
    logic [WI_W-1:0] r_idx;
    logic [1:0]      r_wck;
    logic [31:0]     r_cnt;
    logic            r_halt;
    logic [LP_W-1:0] r_start;
    logic [LEN_W-1:0] r_len, r_i;
    logic [WI_W-1:0] r_ws_addr;
    logic            r_word_fin;   // after word: 0 = normal terminator, 1 = end of stream
    logic            r_tail_byte;  // emit a terminator byte after the word
    logic [7:0]      r_term;

    logic            w_space, q_valid, q_last;
    t_kind           q_kind;
    logic [7:0]      q_byte;
    logic [31:0]     q_count;
    logic            w_in_acc;
    logic            w_room;
    logic [WI_W+6-1:0] w_v;
    logic [5:0]      w_dig;
    logic            w_letter;
    logic [7:0]      w_lc, w_pc;
    logic [WA_W:0]   w_len_full;
    logic [WA_W-1:0] w_raddr;
    t_kind           w_okind;

    assign pready   = 1'b1;
    assign prdata   = r_limit;
    assign o_ready  = (r_st == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_room   = r_cnt < r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 32'hffff_ffff;
        else if (psel && penable && pwrite && paddr == 1'b0) r_limit <= pwdata;
    end

    // index digit
    assign w_letter = is_upper(r_b) || is_lower(r_b);
    assign w_dig = is_upper(r_b) ? 6'(r_b - 8'h41 + 8'd27) : 6'(r_b - 8'h61 + 8'd1);
    assign w_v = (WI_W+6)'(r_idx) * (WI_W+6)'(52) + (WI_W+6)'(w_dig);

    // word letter case
    always_comb begin
        w_lc = r_ch;
        if (r_wck == CASE_ALL || (r_wck == CASE_FIRST && r_i == '0)) w_lc = r_ch - 8'd32;
        w_pc = w_lc;
        if (r_i == '0 && r_capn) begin
            if (is_upper(w_lc)) w_pc = w_lc + 8'd32;
            else if (is_lower(w_lc)) w_pc = w_lc - 8'd32;
        end
    end
    assign w_len_full = (r_ws > r_start) ? r_ws - r_start - 1'b1 : '0;
    assign w_raddr    = r_start[WA_W-1:0] + WA_W'(r_i);

    // memories
    always_ff @(posedge i_clk) begin
        if (r_st == S_DEC && r_mode == MODE_LOAD && r_lpos < LP_W'(DICT_BYTES))
            word_mem[r_lpos[WA_W-1:0]] <= r_b;
        r_ch <= word_mem[w_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (r_st == S_DEC && r_mode == MODE_LOAD && r_lpos < LP_W'(DICT_BYTES)
            && r_b == CH_NL && r_words < WI_W'(DICT_WORDS))
            ws_mem[r_words + 1'b1] <= r_lpos + 1'b1;
        r_ws <= ws_mem[r_ws_addr];
    end

    // result push
    logic    w_push;
    logic [7:0] w_pbyte;
    logic    w_plast;
    always_comb begin
        w_push = 1'b0; w_pbyte = '0; w_plast = 1'b0; w_okind = KIND_BYTE;
        if (r_st == S_EMIT && w_space && r_i < r_len && w_room) begin
            w_push = 1'b1; w_pbyte = w_pc;
            w_plast = !r_word_fin && !r_tail_byte && (r_i == r_len - 1'b1);
        end else if (r_st == S_TAIL && w_space) begin
            if (r_tail_byte && w_room) begin
                w_push = 1'b1; w_pbyte = r_term; w_plast = !r_word_fin;
            end else if (r_word_fin && !r_tail_byte) begin
                w_push = 1'b1; w_okind = r_halt ? KIND_ERR : KIND_OK; w_plast = 1'b1;
            end
        end else if (r_st == S_DEC && w_space && r_mode == MODE_STREAM && !r_halt
                     && r_hdr[2] && w_room) begin
            if (r_ph == PH_ESCAPE) begin
                w_push = 1'b1; w_pbyte = r_b; w_plast = 1'b1;
            end else if (r_ph == PH_NORMAL && r_b != r_code[0] && r_b != r_code[1]
                         && r_b != r_code[2] && r_b != r_code[3]) begin
                w_push = 1'b1; w_plast = 1'b1;
                w_pbyte = (r_capn && is_upper(r_b)) ? r_b + 8'd32 :
                          (r_capn && is_lower(r_b)) ? r_b - 8'd32 : r_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_words <= '0; r_lpos <= '0; r_hdr <= '0;
            r_code <= '{default: 8'd0}; r_capn <= 1'b1; r_ph <= PH_NORMAL;
            r_idx <= '0; r_wck <= '0; r_cnt <= '0; r_halt <= 1'b0;
            r_word_fin <= 1'b0; r_tail_byte <= 1'b0;
        end else begin
            if (w_push && w_okind == KIND_BYTE) r_cnt <= r_cnt + 1'b1;
            unique case (r_st)
                S_IDLE: if (w_in_acc) begin
                    r_mode <= t_mode'(i_mode); r_b <= i_data_byte; r_st <= S_DEC;
                end
                S_DEC: begin
                    r_st <= S_IDLE;
                    r_ws_addr <= r_idx;
                    unique case (r_mode)
                        MODE_LOAD: if (r_lpos < LP_W'(DICT_BYTES)) begin
                            r_lpos <= r_lpos + 1'b1;
                            if (r_b == CH_NL && r_words < WI_W'(DICT_WORDS))
                                r_words <= r_words + 1'b1;
                        end
                        MODE_STREAM: if (!r_halt) begin
                            if (!r_hdr[2]) begin
                                r_code[r_hdr[1:0]] <= r_b; r_hdr <= r_hdr + 1'b1;
                            end else unique case (r_ph)
                                PH_ESCAPE: if (!w_space) r_st <= S_DEC;
                                    else r_ph <= PH_NORMAL;
                                PH_WORDESC: begin
                                    r_term <= r_b; r_tail_byte <= 1'b1;
                                    r_word_fin <= 1'b0;
                                    r_ph <= PH_NORMAL; r_st <= S_ST0;
                                end
                                PH_INDEX: begin
                                    if (w_letter) begin
                                        if (w_v >= (WI_W+6)'(r_words)) begin
                                            r_halt <= 1'b1; r_ph <= PH_NORMAL;
                                        end else r_idx <= WI_W'(w_v);
                                    end else if (r_idx >= r_words) begin
                                        r_halt <= 1'b1; r_ph <= PH_NORMAL;
                                    end else if (r_b == r_code[0]) begin
                                        r_ph <= PH_WORDESC;
                                    end else begin
                                        r_term <= r_b; r_tail_byte <= 1'b1;
                                        r_word_fin <= 1'b0;
                                        r_ph <= PH_NORMAL; r_st <= S_ST0;
                                    end
                                end
                                PH_NORMAL: if (w_room) begin
                                    if (r_b == r_code[0]) begin
                                        r_capn <= 1'b0; r_ph <= PH_ESCAPE;
                                    end else if (r_b == r_code[1] || r_b == r_code[2]
                                                 || r_b == r_code[3]) begin
                                        r_wck <= (r_b == r_code[3]) ? CASE_ALL :
                                                 (r_b == r_code[2]) ? CASE_FIRST
                                                                    : CASE_PLAIN;
                                        r_idx <= '0; r_ph <= PH_INDEX;
                                    end else if (!w_space) begin
                                        r_st <= S_DEC;
                                    end else begin
                                        if (is_send(w_pbyte)) r_capn <= 1'b1;
                                        else if (r_capn && (is_upper(r_b)
                                                 || is_lower(r_b))) r_capn <= 1'b0;
                                        else if (r_b != 8'h20 && r_b != 8'h0a
                                                 && r_b != 8'h0d && r_b != 8'h09)
                                            r_capn <= 1'b0;
                                    end
                                end
                            endcase
                        end
                        MODE_END: begin
                            r_word_fin <= 1'b1; r_tail_byte <= 1'b0;
                            r_st <= S_TAIL;
                            if (r_halt || !r_hdr[2]) r_halt <= 1'b1;
                            else if (r_ph == PH_INDEX) begin
                                if (r_idx >= r_words) r_halt <= 1'b1;
                                else r_st <= S_ST0;
                            end else if (r_ph == PH_WORDESC) begin
                                r_tail_byte <= 1'b1; r_term <= r_code[0];
                                r_st <= S_ST0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ST0: begin
                    r_ws_addr <= r_idx + 1'b1; r_st <= S_ST1;
                end
                S_ST1: begin
                    r_start <= (r_idx == '0) ? '0 : r_ws; r_i <= '0; r_st <= S_RDCH;
                end
                S_RDCH: begin
                    r_len <= (w_len_full > (WA_W+1)'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN)
                             : w_len_full[LEN_W-1:0];
                    r_st <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_i >= r_len) r_st <= S_TAIL;
                    else if (w_space) begin
                        r_i <= r_i + 1'b1;
                        r_st <= (r_i + 1'b1 >= r_len) ? S_TAIL : S_RDCH;
                    end
                end
                S_TAIL: if (w_space) begin
                    if (r_tail_byte) begin
                        r_tail_byte <= 1'b0;
                        if (!r_word_fin) begin
                            r_st <= S_IDLE; r_capn <= is_send(r_term);
                        end
                    end else begin
                        r_st <= S_IDLE;
                        if (r_word_fin) begin
                            r_hdr <= '0; r_code <= '{default: 8'd0}; r_capn <= 1'b1;
                            r_ph <= PH_NORMAL; r_idx <= '0; r_wck <= '0;
                            r_cnt <= '0; r_halt <= 1'b0; r_word_fin <= 1'b0;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // last flag fix-up: when a pending terminator is suppressed by the limit, the
    // final visible byte still needs last; word bytes held back by the limit do too
    assign q_valid = w_push;
    assign q_kind  = w_okind;
    assign q_byte  = w_pbyte;
    assign q_count = (w_okind == KIND_BYTE) ? r_cnt + 1'b1 : r_cnt;
    assign q_last  = w_plast || (r_st == S_EMIT && !r_word_fin && !r_tail_byte
                     && (r_cnt + 1'b1 >= r_limit))
                     || (r_st == S_EMIT && r_tail_byte && !r_word_fin
                     && (r_cnt + 1'b1 >= r_limit));

    dwe_outq u_outq (
        .i_clk, .i_rst_n,
        .i_valid (q_valid), .i_kind (q_kind), .i_byte (q_byte),
        .i_count (q_count), .i_last (q_last), .o_space (w_space),
        .o_valid, .i_ready, .o_kind (o_kind),
        .o_byte (o_out_byte), .o_count (o_byte_count), .o_last
    );

`ifndef SYNTHESIS
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("ready outside idle");
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr <= 3'd4) else $error("header count overrun");
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_kind == KIND_BYTE) |-> (r_cnt < r_limit))
        else $error("byte beyond output limit");
`endif
endmodule
